FILE: rtl/core/snx_pkg.sv
// snx_pkg: shared types, constants and the gradient hash for the simplex noise core.
// No dependencies.
`timescale 1ns / 1ps
package snx_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int COORD_W         = 32;
  localparam int NOISE_W         = 16;
  localparam int OFF_W           = 24;   // offsets in 1/(6*2^F) units, wrapped to 24 bits
  localparam int C_W             = 22;   // corner offset, Q.16
  localparam int G_W             = 24;   // gradient dot product, Q.16
  localparam int TERM_W          = 28;
  localparam int CORNER_LAT      = 7;

  localparam logic [15:0] SIX_TENTHS_Q16 = 16'd39321;
  // floor(m/3) = (m * ceil(2^k/3)) >> k, exact for m < 2^k
  localparam logic [19:0] RECIP3_21 = 20'd699051;
  localparam logic [23:0] RECIP3_25 = 24'd11184811;

  typedef logic signed [OFF_W-1:0] off_t;
  typedef logic        [7:0]       cell8_t;
  typedef logic signed [C_W-1:0]   cofs_t;
  typedef logic signed [TERM_W-1:0] term_t;

  typedef logic [5:0] grad_tab_t [8];
  localparam grad_tab_t GRAD_TAB = '{6'h15, 6'h38, 6'h32, 6'h2c, 6'h0d, 6'h13, 6'h07, 6'h2a};

  function automatic logic [5:0] tab_pick(input logic b2, input logic b1, input logic b0);
    tab_pick = GRAD_TAB[{b2, b1, b0}];
  endfunction

  // Only the low six bits of the sum are ever used.
  function automatic logic [5:0] corner_hash(input cell8_t a, input cell8_t b, input cell8_t c);
    corner_hash = tab_pick(a[0], b[0], c[0]) + tab_pick(b[1], c[1], a[1])
                + tab_pick(c[2], a[2], b[2]) + tab_pick(a[3], b[3], c[3])
                + tab_pick(b[4], c[4], a[4]) + tab_pick(c[5], a[5], b[5])
                + tab_pick(a[6], b[6], c[6]) + tab_pick(b[7], c[7], a[7]);
  endfunction

endpackage

FILE: rtl/core/snx_skew.sv
// snx_skew: skew to the cell, true floor by three, unskewed offsets (three stages).
// Depends on snx_pkg.
`timescale 1ns / 1ps
module snx_skew import snx_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic signed [COORD_W-1:0] x_coord,
  input  logic signed [COORD_W-1:0] y_coord,
  input  logic signed [COORD_W-1:0] z_coord,
  output logic                      out_valid,
  output cell8_t                    cell8 [3],
  output off_t                      off6 [3]
);

  logic signed [33:0] sum_s;
  logic signed [35:0] num   [3];
  logic signed [31:0] pt    [3];
  logic signed [19:0] a_r   [3];
  logic [23:0]        p1_r  [3];
  logic [23:0]        p2_r  [3];
  logic [20:0]        m_s   [3];
  logic [40:0]        prod  [3];
  cell8_t             c2_r  [3];
  cell8_t             c3_r  [3];
  cell8_t             csum;
  off_t               off_r [3];
  logic               v1_r, v2_r, v3_r;

  always_comb begin
    pt[0] = x_coord;
    pt[1] = y_coord;
    pt[2] = z_coord;
    sum_s = 34'(x_coord) + 34'(y_coord) + 34'(z_coord);
    for (int n = 0; n < 3; n++) begin
      num[n] = (36'(pt[n]) <<< 1) + 36'(pt[n]) + 36'(sum_s);
      m_s[n] = 21'(22'(a_r[n]) + 22'sd786432);
      prod[n] = 41'(m_s[n]) * 41'(RECIP3_21);
    end
    csum = c2_r[0] + c2_r[1] + c2_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < 3; n++) begin
        a_r[n]  <= num[n][35:16];
        p1_r[n] <= pt[n][23:0];
        p2_r[n] <= p1_r[n];
        // the 2^18 bias has no low eight bits, so the cell's low byte drops out directly
        c2_r[n] <= prod[n][28:21];
        c3_r[n] <= c2_r[n];
        off_r[n] <= (p2_r[n] << 2) + (p2_r[n] << 1)
                  - ({c2_r[n], 16'h0} << 2) - ({c2_r[n], 16'h0} << 1)
                  + {csum, 16'h0};
      end
    end
  end

  assign out_valid = v3_r;
  assign cell8 = c3_r;
  assign off6  = off_r;

endmodule

FILE: rtl/core/snx_corner.sv
// snx_corner: one corner term 8*t^4*(grad . offset) in Q.16, seven stages.
// Depends on snx_pkg.
`timescale 1ns / 1ps
module snx_corner import snx_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  off_t       off6 [3],
  input  cell8_t     cell8 [3],
  input  logic [2:0] disp,
  output term_t      term
);

  logic [1:0]          csum_c;
  logic signed [24:0]  e_s  [3];
  logic signed [23:0]  h_s  [3];
  logic [23:0]         m_r  [3];
  cell8_t              hc_r [3];
  logic [47:0]         prod [3];
  cofs_t               c_r  [3];
  logic [5:0]          h2_r;
  logic [43:0]         csq  [3];
  logic [27:0]         sq_r [3];
  logic signed [G_W-1:0] g_s, pp, qq, rr;
  logic signed [G_W-1:0] g3_r, g4_r, g5_r, g6_r;
  logic signed [31:0]  t_s;
  logic [15:0]         tt_r, t2_r, t4_r;
  logic [31:0]         t2_p, t4_p;
  logic signed [40:0]  tg;
  logic signed [43:0]  tg8;
  term_t               term_r;

  always_comb begin
    csum_c = 2'(disp[0]) + 2'(disp[1]) + 2'(disp[2]);
    for (int n = 0; n < 3; n++) begin
      e_s[n] = 25'(off6[n]) - (disp[n] ? 25'sd393216 : 25'sd0)
             + 25'($signed({1'b0, csum_c, 16'h0}));
      h_s[n] = e_s[n][24:1];
      prod[n] = 48'(m_r[n]) * 48'(RECIP3_25);
      csq[n] = 44'(c_r[n]) * 44'(c_r[n]);
    end
    unique case (h2_r[1:0])
      2'd1:    begin pp = G_W'(c_r[0]); qq = G_W'(c_r[1]); rr = G_W'(c_r[2]); end
      2'd2:    begin pp = G_W'(c_r[1]); qq = G_W'(c_r[2]); rr = G_W'(c_r[0]); end
      default: begin pp = G_W'(c_r[2]); qq = G_W'(c_r[0]); rr = G_W'(c_r[1]); end
    endcase
    if (h2_r[5] == h2_r[3]) pp = -pp;
    if (h2_r[5] == h2_r[4]) qq = -qq;
    if (h2_r[5] != (h2_r[4] ^ h2_r[3])) rr = -rr;
    g_s = pp + ((h2_r[1:0] == 2'd0) ? (qq + rr) : (h2_r[2] ? rr : qq));
    t_s = 32'($signed({1'b0, SIX_TENTHS_Q16})) - 32'($signed({1'b0, sq_r[0]}))
        - 32'($signed({1'b0, sq_r[1]})) - 32'($signed({1'b0, sq_r[2]}));
    t2_p = tt_r * tt_r;
    t4_p = t2_r * t2_r;
    tg   = $signed({1'b0, t4_r}) * 41'(g6_r);
    tg8  = 44'(tg) <<< 3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < 3; n++) begin
        m_r[n]  <= 24'(25'(h_s[n]) + 25'sd6291456);
        hc_r[n] <= cell8[n] + 8'(disp[n]);
        c_r[n]  <= C_W'($signed({1'b0, prod[n][47:25]}) - 24'sd2097152);
        sq_r[n] <= csq[n][43:16];
      end
      h2_r   <= corner_hash(hc_r[0], hc_r[1], hc_r[2]);
      g3_r   <= g_s;
      tt_r   <= (t_s > 32'sd0) ? t_s[15:0] : 16'd0;
      g4_r   <= g3_r;
      t2_r   <= t2_p[31:16];
      g5_r   <= g4_r;
      t4_r   <= t2_r == 16'd0 ? 16'd0 : t4_p[31:16];
      g6_r   <= g5_r;
      term_r <= tg8[43:16];
    end
  end

  assign term = term_r;

endmodule

FILE: rtl/core/simplex_noise_3d.sv
// 3D simplex noise: one Q15.16 point per transaction in, one saturated Q0.15 sample out.
// One point is taken every cycle while the output is taken;
// the whole pipeline advances together, so a stall on out_tready holds every stage.
// Uses snx_pkg, snx_skew and snx_corner (four instances, one per tetrahedron corner).
`timescale 1ns / 1ps
module simplex_noise_3d import snx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // [31:0] x_coord, [63:32] y_coord, [95:64] z_coord
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [15:0] noise_value
);

  logic       en;
  logic       sk_valid;
  cell8_t     sk_cell [3];
  off_t       sk_off  [3];
  cell8_t     sel_cell_r [3];
  off_t       sel_off_r  [3];
  logic [2:0] d1_r, d2_r;
  logic [1:0] hi, lo, mid;
  logic [2:0] hi_oh, mid_oh;
  logic [CORNER_LAT:0] vld_r;
  term_t      terms [4];
  logic signed [TERM_W+1:0] acc;
  logic signed [TERM_W:0]   half;
  logic [15:0] out_r;
  logic        out_v_r;

  assign en        = !out_v_r || out_tready;
  assign in_tready = en;

  snx_skew u_skew (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_tvalid && in_tready),
    .x_coord(in_tdata[31:0]), .y_coord(in_tdata[63:32]), .z_coord(in_tdata[95:64]),
    .out_valid(sk_valid), .cell8(sk_cell), .off6(sk_off)
  );

  // tetrahedron choice; ties break toward the lower axis for hi, higher for lo
  always_comb begin
    if (sk_off[0] >= sk_off[2]) hi = (sk_off[0] >= sk_off[1]) ? 2'd0 : 2'd1;
    else                        hi = (sk_off[1] >= sk_off[2]) ? 2'd1 : 2'd2;
    if (sk_off[0] < sk_off[2])  lo = (sk_off[0] < sk_off[1]) ? 2'd0 : 2'd1;
    else                        lo = (sk_off[1] < sk_off[2]) ? 2'd1 : 2'd2;
    mid    = 2'd3 - hi - lo;
    hi_oh  = 3'b001 << hi;
    mid_oh = 3'b001 << mid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel_cell_r <= sk_cell;
      sel_off_r  <= sk_off;
      d1_r       <= hi_oh;
      d2_r       <= hi_oh | mid_oh;
    end
  end

  snx_corner u_c0 (.clk(clk), .en(en), .off6(sel_off_r), .cell8(sel_cell_r),
                   .disp(3'b000), .term(terms[0]));
  snx_corner u_c1 (.clk(clk), .en(en), .off6(sel_off_r), .cell8(sel_cell_r),
                   .disp(d1_r), .term(terms[1]));
  snx_corner u_c2 (.clk(clk), .en(en), .off6(sel_off_r), .cell8(sel_cell_r),
                   .disp(d2_r), .term(terms[2]));
  snx_corner u_c3 (.clk(clk), .en(en), .off6(sel_off_r), .cell8(sel_cell_r),
                   .disp(3'b111), .term(terms[3]));

  always_comb begin
    acc  = (TERM_W+2)'(terms[0]) + (TERM_W+2)'(terms[1])
         + (TERM_W+2)'(terms[2]) + (TERM_W+2)'(terms[3]);
    half = acc[TERM_W+1:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      vld_r   <= {vld_r[CORNER_LAT-1:0], sk_valid};
      out_v_r <= vld_r[CORNER_LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (half > (TERM_W+1)'(32767))       out_r <= 16'h7fff;
      else if (half < -(TERM_W+1)'(32768)) out_r <= 16'h8000;
      else                                 out_r <= half[15:0];
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid && vld_r == '0)
    else $error("pipeline not empty after reset");
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r) && $stable(out_r))
    else $error("pipeline moved during output stall");
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(vld_r[CORNER_LAT]))
    else $error("result appeared without a tracked item");

endmodule
